### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_CHAR_62 = 2'd0;
    localparam logic [1:0] CFG_CHAR_63 = 2'd1;
    localparam logic [1:0] CFG_PAD     = 2'd2;

    localparam logic [7:0] CHAR_62_RST = 8'd43;
    localparam logic [7:0] CHAR_63_RST = 8'd47;
    localparam logic [7:0] PAD_RST     = 8'd61;

    localparam logic [7:0] WS_TAB   = 8'd9;
    localparam logic [7:0] WS_CR    = 8'd13;
    localparam logic [7:0] WS_SPACE = 8'd32;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_BAD    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] char_62;
        logic [7:0] char_63;
        logic [7:0] pad;
    } cfg_t;

    // one queue entry: all results caused by one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]      nbytes;  // 0 means a bare end result
        logic            last;
        status_t         status;
    } entry_t;

    // {found, value}
    function automatic logic [6:0] alpha_lookup(input logic [7:0] c,
                                                input logic [7:0] c62,
                                                input logic [7:0] c63);
        logic [6:0] r;
        begin
            if (c >= 8'd65 && c <= 8'd90) begin
                r = {1'b1, 6'(c - 8'd65)};
            end else if (c >= 8'd97 && c <= 8'd122) begin
                r = {1'b1, 6'(c - 8'd71)};
            end else if (c >= 8'd48 && c <= 8'd57) begin
                r = {1'b1, 6'(c + 8'd4)};
            end else if (c == c62) begin
                r = {1'b1, 6'd62};
            end else if (c == c63) begin
                r = {1'b1, 6'd63};
            end else begin
                r = 7'd0;
            end
            return r;
        end
    endfunction

endpackage

### design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, tracks group and padding state and builds
// one queue entry per item that yields results.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              has_char,
    input  logic              end_of_text,
    output logic              push,
    output b64d_pkg::entry_t  push_entry
);

    b64d_pkg::cfg_t cfg_reg;

    logic [17:0] buf_reg, buf_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pads_reg, pads_next;
    logic        trail_reg, trail_next;
    logic        err_reg, err_next;

    logic        is_ws;
    logic [6:0]  look;
    logic        pad_err;
    b64d_pkg::entry_t ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.char_62 <= b64d_pkg::CHAR_62_RST;
            cfg_reg.char_63 <= b64d_pkg::CHAR_63_RST;
            cfg_reg.pad     <= b64d_pkg::PAD_RST;
        end else if (cfg_valid) begin
            if (cfg_index == b64d_pkg::CFG_CHAR_62) cfg_reg.char_62 <= cfg_data;
            if (cfg_index == b64d_pkg::CFG_CHAR_63) cfg_reg.char_63 <= cfg_data;
            if (cfg_index == b64d_pkg::CFG_PAD)     cfg_reg.pad     <= cfg_data;
        end
    end

    assign is_ws = (char_code >= b64d_pkg::WS_TAB && char_code <= b64d_pkg::WS_CR) ||
                   (char_code == b64d_pkg::WS_SPACE);
    assign look  = b64d_pkg::alpha_lookup(char_code, cfg_reg.char_62, cfg_reg.char_63);

    always_comb begin
        buf_next   = buf_reg;
        pos_next   = pos_reg;
        pads_next  = pads_reg;
        trail_next = trail_reg;
        err_next   = err_reg;
        pad_err    = 1'b0;
        ent        = '0;

        if (has_char) begin
            if (is_ws) begin
                trail_next = 1'b1;
            end else if (trail_reg) begin
                err_next = 1'b1;
            end else begin
                pos_next = pos_reg + 2'd1;
                if (char_code == cfg_reg.pad) begin
                    pad_err   = err_reg || (pos_reg < 2'd2) || (pads_reg >= 2'd2);
                    err_next  = pad_err;
                    pads_next = (pads_reg == 2'd3) ? pads_reg : pads_reg + 2'd1;
                    if (pos_reg == 2'd3 && !pad_err) begin
                        if (pads_next == 2'd2) begin
                            ent.bytes[0] = buf_reg[11:4];
                            ent.nbytes   = 2'd1;
                        end else begin
                            ent.bytes[0] = buf_reg[17:10];
                            ent.bytes[1] = buf_reg[9:2];
                            ent.nbytes   = 2'd2;
                        end
                    end
                end else if (!look[6] || pads_reg != 2'd0) begin
                    err_next = 1'b1;
                end else if (pos_reg == 2'd3) begin
                    if (!err_reg) begin
                        ent.bytes[0] = buf_reg[17:10];
                        ent.bytes[1] = buf_reg[9:2];
                        ent.bytes[2] = {buf_reg[1:0], look[5:0]};
                        ent.nbytes   = 2'd3;
                    end
                    buf_next = '0;
                end else begin
                    buf_next = {buf_reg[11:0], look[5:0]};
                end
            end
        end

        if (end_of_text) begin
            ent.last = 1'b1;
            if (pos_next != 2'd0) begin
                ent.status = b64d_pkg::STATUS_LENGTH;
            end else if (err_next) begin
                ent.status = b64d_pkg::STATUS_BAD;
            end else begin
                ent.status = b64d_pkg::STATUS_OK;
            end
            // start the next text from a clean state
            buf_next   = '0;
            pos_next   = '0;
            pads_next  = '0;
            trail_next = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg   <= '0;
            pos_reg   <= '0;
            pads_reg  <= '0;
            trail_reg <= 1'b0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            buf_reg   <= buf_next;
            pos_reg   <= pos_next;
            pads_reg  <= pads_next;
            trail_reg <= trail_next;
            err_reg   <= err_next;
        end
    end

    assign push       = accept && (ent.nbytes != 2'd0 || end_of_text);
    assign push_entry = ent;

endmodule

### design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64d_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output b64d_pkg::entry_t  head
);

    b64d_pkg::entry_t                  slot_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QPTR_W-1:0]       wr_reg, rd_reg;
    logic [b64d_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign full  = (cnt_reg == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= push_entry;
    end

endmodule

### design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes queue entries and sends their results out one transfer at a time.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  b64d_pkg::entry_t  head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [2:0]        m_tuser
);

    b64d_pkg::entry_t entry_reg;
    logic             busy_reg;
    logic [1:0]       idx_reg;
    logic [1:0]       beats;
    logic             final_beat;
    logic             done;
    logic             has_data;
    logic             is_last;

    assign beats      = (entry_reg.nbytes == 2'd0) ? 2'd1 : entry_reg.nbytes;
    assign final_beat = (idx_reg == beats - 2'd1);
    assign done       = busy_reg && m_tready && final_beat;
    // refill on the final transfer so single-result entries stream every cycle while m_tready is high
    assign pop        = !empty && (!busy_reg || done);

    assign has_data = (entry_reg.nbytes != 2'd0);
    assign is_last  = entry_reg.last && final_beat;

    assign m_tvalid = busy_reg;
    assign m_tdata  = has_data ? entry_reg.bytes[idx_reg] : 8'd0;
    assign m_tlast  = is_last;
    assign m_tuser  = {(is_last ? entry_reg.status : b64d_pkg::STATUS_OK), has_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (done) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) entry_reg <= head;
    end

endmodule

### design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with configurable value-62/63 and pad characters.
// ----------------------------------------------------------------------------
// When the output side is idle, the first result of an item passes through a
//   queue write, then an output register load, before it is valid.
// Throughput: one character per cycle while the four-entry queue has room;
//   the output side sends one result per cycle while m_tready is high.
// Reset: synchronous active-low aresetn restores the default alphabet and pad,
//   clears the decode state and empties the queue.
module base64_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_text
    input  logic       s_tuser,   // [0] has_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,   // last
    output logic [2:0] m_tuser    // [0] has_data, [2:1] status
);

    logic             accept;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    b64d_pkg::entry_t push_entry;
    b64d_pkg::entry_t head;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .char_code   (s_tdata),
        .has_char    (s_tuser),
        .end_of_text (s_tlast),
        .push        (push),
        .push_entry  (push_entry)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### design/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // results without a byte exist only to close a text
    a_bare_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("bare result without last");

    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("bare result carries nonzero data");

    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
        else $error("status set on a result that is not last");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
